// ----- rtl/core/mf3_pkg.sv -----
// mf3_pkg: shared constants and types of the 3x3 rgb median filter
// no dependencies; used by every module in rtl/core but mf3_ram
package mf3_pkg;

  // line store depth default and window size
  localparam int MAX_WIDTH   = 2048;
  localparam int WINDOW_TAPS = 9;

  // field widths
  localparam int CHAN_W  = 8;
  localparam int PIX_W   = 3 * CHAN_W;
  localparam int FW_W    = 12;   // frame_width register
  localparam int FH_W    = 16;   // frame_height register
  localparam int CFG_W   = 16;   // widest register
  localparam int CFG_IDX_W = 2;
  localparam int ROW_W   = 17;   // row can reach frame_height+1

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

  // reset values of the registers
  localparam int FRAME_WIDTH_RST  = 512;
  localparam int FRAME_HEIGHT_RST = 512;

  // request kinds
  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_FLUSH = 1'b1;

  // compare-exchange pairs of the 19-step median-of-nine network
  localparam int MED_STEPS = 19;
  typedef logic [3:0] tap_idx_t;
  localparam tap_idx_t MED_LO [MED_STEPS] = '{
    4'd1, 4'd4, 4'd7, 4'd0, 4'd3, 4'd6, 4'd1, 4'd4, 4'd7, 4'd0,
    4'd5, 4'd4, 4'd3, 4'd1, 4'd2, 4'd4, 4'd4, 4'd6, 4'd4};
  localparam tap_idx_t MED_HI [MED_STEPS] = '{
    4'd2, 4'd5, 4'd8, 4'd1, 4'd4, 4'd7, 4'd2, 4'd5, 4'd8, 4'd3,
    4'd8, 4'd7, 4'd6, 4'd4, 4'd5, 4'd7, 4'd2, 4'd4, 4'd2};

  typedef logic [WINDOW_TAPS-1:0][CHAN_W-1:0] taps_t;

endpackage

// ----- rtl/core/median_filter_3x3_rgb.sv -----
// median_filter_3x3_rgb: 3x3 median filter over an rgb raster pixel stream
// depends on mf3_pkg, mf3_line_buf, mf3_median
//
//  channel  | direction | handshake               | payload
//  ---------+-----------+-------------------------+---------------------------------
//  input    | in        | in_valid_i / in_stall_o | req_type_i, in_red/green/blue_i
//  result   | out       | out_valid_o/out_stall_i | out_red/green/blue_o, frame_last_o
//  config   | in        | cfg_we_i                | cfg_index_i, cfg_data_i
//
// one item per cycle while the output is not stalled; after its item's transfer a
// result passes the line store read at the transfer, the window shift, then the median
// into the output register.
// the line store ram read port and the output register set the pace.
// a stalled output freezes the whole pipeline and stalls the input.
// no clearing pass after reset: every stored pixel that reaches a result was
// written earlier in the same frame.
module median_filter_3x3_rgb #(
  parameter int MaxWidth = mf3_pkg::MAX_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              req_type_i,
  input  logic [mf3_pkg::CHAN_W-1:0]        in_red_i,
  input  logic [mf3_pkg::CHAN_W-1:0]        in_green_i,
  input  logic [mf3_pkg::CHAN_W-1:0]        in_blue_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [mf3_pkg::CHAN_W-1:0]        out_red_o,
  output logic [mf3_pkg::CHAN_W-1:0]        out_green_o,
  output logic [mf3_pkg::CHAN_W-1:0]        out_blue_o,
  output logic                              frame_last_o,
  input  logic                              cfg_we_i,
  input  logic [mf3_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [mf3_pkg::CFG_W-1:0]         cfg_data_i
);

  localparam int CntW = $clog2(MaxWidth);
  localparam int WRstEff = (MaxWidth < mf3_pkg::FRAME_WIDTH_RST) ?
                           MaxWidth : mf3_pkg::FRAME_WIDTH_RST;
  localparam logic [CntW-1:0] WLastRst = CntW'(WRstEff - 1);
  localparam logic [mf3_pkg::FH_W-1:0] HLastRst =
    mf3_pkg::FH_W'(mf3_pkg::FRAME_HEIGHT_RST - 1);
  localparam int CW = mf3_pkg::CHAN_W;
  localparam int PW = mf3_pkg::PIX_W;

  // effective frame size, kept as last column and last row
  logic [CntW-1:0]             w_last_q, w_last_d;
  logic [mf3_pkg::FH_W-1:0]    h_last_q, h_last_d;
  logic [mf3_pkg::FW_W-1:0]    fw;
  logic [mf3_pkg::FH_W-1:0]    fh;

  // position of the next item
  logic [CntW-1:0]             col_q, col_d;
  logic [mf3_pkg::ROW_W-1:0]   row_q, row_d;

  logic advance, in_xfer, cfg_restart;
  logic emit, border, last;
  logic [mf3_pkg::ROW_W-1:0]   orow;
  logic [mf3_pkg::ROW_W-1:0]   h_last_ext;
  logic [PW-1:0]               px;

  // stage 1: line store read in flight
  logic                        s1_valid_q, s1_emit_q, s1_border_q, s1_last_q;
  logic [CntW-1:0]             s1_col_q;
  logic [PW-1:0]               s1_px_q;
  logic [PW-1:0]               up, lo;

  // stage 2: window holds the item's neighborhood
  logic [2:0][2:0][PW-1:0]     win_q;
  logic                        s2_valid_q, s2_border_q, s2_last_q;

  // output register
  logic                        out_valid_q, out_last_q, out_border_q;
  logic [PW-1:0]               out_px_q, out_px_d;
  logic [2:0][CW-1:0]          med;
  mf3_pkg::taps_t [2:0]        taps;

  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = !advance;
  assign in_xfer    = in_valid_i && advance;
  assign cfg_restart = cfg_we_i &&
    ((cfg_index_i == mf3_pkg::CFG_FRAME_WIDTH) || (cfg_index_i == mf3_pkg::CFG_FRAME_HEIGHT));

  // register clamping
  always_comb begin
    fw = cfg_data_i[mf3_pkg::FW_W-1:0];
    fh = cfg_data_i[mf3_pkg::FH_W-1:0];
    if (fw < mf3_pkg::FW_W'(3)) begin
      w_last_d = CntW'(2);
    end else if (32'(fw) > MaxWidth) begin
      w_last_d = CntW'(MaxWidth - 1);
    end else begin
      w_last_d = CntW'(fw - mf3_pkg::FW_W'(1));
    end
    if (fh < mf3_pkg::FH_W'(3)) begin
      h_last_d = mf3_pkg::FH_W'(2);
    end else begin
      h_last_d = fh - mf3_pkg::FH_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      w_last_q <= WLastRst;
      h_last_q <= HLastRst;
    end else if (cfg_we_i) begin
      if (cfg_index_i == mf3_pkg::CFG_FRAME_WIDTH) begin
        w_last_q <= w_last_d;
      end else if (cfg_index_i == mf3_pkg::CFG_FRAME_HEIGHT) begin
        h_last_q <= h_last_d;
      end
    end
  end

  // result position for the item at the current input position
  assign h_last_ext = {1'b0, h_last_q};
  always_comb begin
    emit   = (row_q >= mf3_pkg::ROW_W'(2)) ||
             ((row_q == mf3_pkg::ROW_W'(1)) && (col_q != '0));
    orow   = (col_q != '0) ? (row_q - mf3_pkg::ROW_W'(1)) : (row_q - mf3_pkg::ROW_W'(2));
    // column zero means the result sits on the last column of the line above
    border = (col_q == '0) || (col_q == CntW'(1)) ||
             (orow == '0) || (orow >= h_last_ext);
    last   = (col_q == '0) && (orow >= h_last_ext);
    px     = (req_type_i == mf3_pkg::REQ_FLUSH) ? '0 : {in_red_i, in_green_i, in_blue_i};
    if (emit && last) begin
      col_d = '0;
      row_d = '0;
    end else if (col_q == w_last_q) begin
      col_d = '0;
      row_d = row_q + mf3_pkg::ROW_W'(1);
    end else begin
      col_d = col_q + CntW'(1);
      row_d = row_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_restart) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_xfer) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  mf3_line_buf #(.MaxWidth(MaxWidth)) u_line_buf (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (in_xfer),
    .rd_addr_i (col_q),
    .wr_en_i   (advance && s1_valid_q),
    .wr_addr_i (s1_col_q),
    .wr_px_i   (s1_px_q),
    .up_o      (up),
    .lo_o      (lo)
  );

  // pipeline control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      s1_valid_q  <= in_valid_i;
      s2_valid_q  <= s1_valid_q && s1_emit_q;
      out_valid_q <= s2_valid_q;
    end
  end

  // pipeline payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_px_q     <= px;
      s1_col_q    <= col_q;
      s1_emit_q   <= emit;
      s1_border_q <= border;
      s1_last_q   <= last;
    end
    if (advance && s1_valid_q) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= up;
      win_q[1][2] <= lo;
      win_q[2][2] <= s1_px_q;
      s2_border_q <= s1_border_q;
      s2_last_q   <= s1_last_q;
    end
    if (advance && s2_valid_q) begin
      out_px_q     <= out_px_d;
      out_last_q   <= s2_last_q;
      out_border_q <= s2_border_q;
    end
  end

  // per-channel taps, red in the top byte
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      for (int r = 0; r < 3; r++) begin
        for (int k = 0; k < 3; k++) begin
          taps[ch][r * 3 + k] = win_q[r][k][(2 - ch) * CW +: CW];
        end
      end
    end
  end

  for (genvar ch = 0; ch < 3; ch++) begin : g_med
    mf3_median u_median (
      .taps_i   (taps[ch]),
      .median_o (med[ch])
    );
  end

  assign out_px_d = s2_border_q ? win_q[1][1] : {med[0], med[1], med[2]};

  assign out_valid_o  = out_valid_q;
  assign out_red_o    = out_px_q[2 * CW +: CW];
  assign out_green_o  = out_px_q[CW +: CW];
  assign out_blue_o   = out_px_q[0 +: CW];
  assign frame_last_o = out_last_q;

`ifndef NO_ASSERTIONS
  // the frame's last result always lies on the border
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && frame_last_o) |-> out_border_q)
    else $error("frame_last on a non-border result");

  // the column counter stays inside the line
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= w_last_q)
    else $error("column position beyond line width");

  // the row counter never runs past the final drain row
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q <= (h_last_ext + mf3_pkg::ROW_W'(2)))
    else $error("row position beyond frame");

  // the item that causes the frame's last result restarts the position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && emit && last && !cfg_restart) |=> (col_q == '0 && row_q == '0))
    else $error("position not restarted after frame end");
`endif

endmodule

// ----- rtl/core/mf3_ram.sv -----
// mf3_ram: generic single-port-write, single-port-read ram, registered read
// no dependencies
module mf3_ram #(
  parameter int Width = 24,
  parameter int Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output logic [Width-1:0]         rd_data_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

// ----- rtl/core/mf3_line_buf.sv -----
// mf3_line_buf: the two line stores with write-to-read forwarding
// depends on mf3_pkg and mf3_ram
module mf3_line_buf #(
  parameter int MaxWidth = mf3_pkg::MAX_WIDTH
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              rd_en_i,
  input  logic [$clog2(MaxWidth)-1:0]       rd_addr_i,
  input  logic                              wr_en_i,
  input  logic [$clog2(MaxWidth)-1:0]       wr_addr_i,
  input  logic [mf3_pkg::PIX_W-1:0]         wr_px_i,
  output logic [mf3_pkg::PIX_W-1:0]         up_o,
  output logic [mf3_pkg::PIX_W-1:0]         lo_o
);

  logic [mf3_pkg::PIX_W-1:0] ram_up, ram_lo;
  logic [mf3_pkg::PIX_W-1:0] fwd_up_q, fwd_lo_q;
  logic                      fwd_q;

  // the lower line moves up as the new pixel lands in the lower line
  mf3_ram #(.Width(mf3_pkg::PIX_W), .Depth(MaxWidth)) u_upper (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en_i),
    .wr_addr_i (wr_addr_i),
    .wr_data_i (lo_o),
    .rd_en_i   (rd_en_i),
    .rd_addr_i (rd_addr_i),
    .rd_data_o (ram_up)
  );

  mf3_ram #(.Width(mf3_pkg::PIX_W), .Depth(MaxWidth)) u_lower (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en_i),
    .wr_addr_i (wr_addr_i),
    .wr_data_i (wr_px_i),
    .rd_en_i   (rd_en_i),
    .rd_addr_i (rd_addr_i),
    .rd_data_o (ram_lo)
  );

  // same column read and written in one cycle happens after a frame restart
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i && wr_en_i) begin
      fwd_up_q <= lo_o;
      fwd_lo_q <= wr_px_i;
    end
  end

  assign up_o = fwd_q ? fwd_up_q : ram_up;
  assign lo_o = fwd_q ? fwd_lo_q : ram_lo;

endmodule

// ----- rtl/core/mf3_median.sv -----
// mf3_median: median of nine 8-bit values by a compare-exchange network
// depends on mf3_pkg
module mf3_median (
  input  mf3_pkg::taps_t              taps_i,
  output logic [mf3_pkg::CHAN_W-1:0]  median_o
);

  mf3_pkg::taps_t v;
  logic [mf3_pkg::CHAN_W-1:0] tmp;

  // about nine compare levels deep; only the middle entry is sorted for sure
  always_comb begin
    v = taps_i;
    tmp = '0;
    for (int s = 0; s < mf3_pkg::MED_STEPS; s++) begin
      if (v[mf3_pkg::MED_LO[s]] > v[mf3_pkg::MED_HI[s]]) begin
        tmp = v[mf3_pkg::MED_LO[s]];
        v[mf3_pkg::MED_LO[s]] = v[mf3_pkg::MED_HI[s]];
        v[mf3_pkg::MED_HI[s]] = tmp;
      end
    end
  end

  assign median_o = v[mf3_pkg::WINDOW_TAPS / 2];

endmodule
